// ----- sv/rat_pkg.sv -----
// rat_pkg: shared types, constants and helpers of the resource accounting table
// used by every module of the block but rat_ram; depends on nothing
`default_nettype none

package rat_pkg;

  // table geometry and field widths
  localparam int TableEntries = 64;
  localparam int SlotBits     = $clog2(TableEntries);
  localparam int CatBits      = 8;
  localparam int CountBits    = 16;
  localparam int FmtBits      = 4;
  localparam int UnitBits     = 36;
  localparam int SizeBits     = 32;
  localparam int BytesBits    = 52;
  localparam int TotCntBits   = 22;
  localparam int TotBytesBits = 58;

  localparam logic [FmtBits-1:0]   BufferFormat = 4'd11;
  localparam logic [FmtBits-1:0]   NumFormats   = 4'd11;
  localparam logic [CountBits-1:0] CountMax     = {CountBits{1'b1}};

  // operation codes
  localparam logic [2:0] OP_TRACK_IMG   = 3'd0;
  localparam logic [2:0] OP_UNTRACK_IMG = 3'd1;
  localparam logic [2:0] OP_TRACK_BUF   = 3'd2;
  localparam logic [2:0] OP_UNTRACK_BUF = 3'd3;
  localparam logic [2:0] OP_CLEAR       = 3'd4;
  localparam logic [2:0] OP_TOTALS      = 3'd5;
  localparam logic [2:0] OP_READ        = 3'd6;

  // result status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_INVALID   = 3'd1;
  localparam logic [2:0] ST_NOT_FOUND = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_EMPTY     = 3'd4;
  localparam logic [2:0] ST_SAT       = 3'd5;

  typedef struct packed {
    logic [2:0]          opcode;
    logic [CatBits-1:0]  category_id;
    logic [FmtBits-1:0]  format_code;
    logic [15:0]         width;
    logic [15:0]         height;
    logic [31:0]         byte_count;
    logic [5:0]          slot_select;
  } in_t;

  typedef struct packed {
    logic [2:0]              status;
    logic [5:0]              slot_index;
    logic [CatBits-1:0]      entry_category;
    logic [FmtBits-1:0]      entry_format;
    logic [CountBits-1:0]    entry_count;
    logic [BytesBits-1:0]    entry_bytes;
    logic [15:0]             entry_width;
    logic [15:0]             entry_height;
    logic [TotCntBits-1:0]   image_count;
    logic [TotBytesBits-1:0] image_bytes;
    logic [TotCntBits-1:0]   buffer_count;
    logic [TotBytesBits-1:0] buffer_bytes;
  } out_t;

  // one table entry as kept in the entry ram
  typedef struct packed {
    logic [CatBits-1:0]   cat;
    logic [FmtBits-1:0]   fmt;
    logic [UnitBits-1:0]  unit;
    logic [CountBits-1:0] count;
    logic [SizeBits-1:0]  size;
  } rec_t;

  localparam int RecBits = $bits(rec_t);

  // controller to datapath strobes, one per step but the entry ram read
  typedef struct packed {
    logic accept;
    logic mul_wh;
    logic mul_bpp;
    logic lookup;
    logic update;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } sts_t;

  // bytes per pixel of each known format
  function automatic logic [3:0] pixel_bytes(input logic [FmtBits-1:0] fmt);
    logic [3:0] b;
    case (fmt)
      4'd0:    b = 4'd4;
      4'd1:    b = 4'd8;
      4'd2:    b = 4'd2;
      4'd3:    b = 4'd4;
      4'd4:    b = 4'd2;
      4'd5:    b = 4'd4;
      4'd6:    b = 4'd4;
      4'd7:    b = 4'd4;
      4'd8:    b = 4'd12;
      4'd9:    b = 4'd1;
      4'd10:   b = 4'd3;
      default: b = 4'd0;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// ----- sv/rat_ram.sv -----
// rat_ram: generic single-port ram, one write or read a cycle, registered read
// standalone, no package needed
`default_nettype none

module rat_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output      logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write or registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

`default_nettype wire

// ----- sv/rat_ctrl.sv -----
// rat_ctrl: sequencer of the resource accounting table
// depends on rat_pkg for the command and status structs
`default_nettype none

module rat_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output      logic          in_stall_o,
  input  wire rat_pkg::sts_t sts_i,
  output      rat_pkg::cmd_t cmd_o
);
  import rat_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MWH  = 3'd1;
  localparam logic [2:0] S_MBPP = 3'd2;
  localparam logic [2:0] S_LOOK = 3'd3;
  localparam logic [2:0] S_UPD  = 3'd4;
  localparam logic [2:0] S_EMIT = 3'd5;
  localparam logic [2:0] S_RAM  = 3'd6;

  logic [2:0] state_q, state_d;

  // next state and step strobes
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_MWH;
        end
      end
      S_MWH: begin
        cmd_o.mul_wh = 1'b1;
        state_d      = S_MBPP;
      end
      S_MBPP: begin
        cmd_o.mul_bpp = 1'b1;
        state_d       = S_LOOK;
      end
      S_LOOK: begin
        cmd_o.lookup = 1'b1;
        state_d      = S_RAM;
      end
      // entry ram read of the looked-up slot
      S_RAM: begin
        state_d = S_UPD;
      end
      S_UPD: begin
        cmd_o.update = 1'b1;
        state_d      = S_EMIT;
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ----- sv/rat_dpath.sv -----
// rat_dpath: key compare, entry ram, totals and result register
// depends on rat_pkg and rat_ram
`default_nettype none

module rat_dpath (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire rat_pkg::cmd_t cmd_i,
  output      rat_pkg::sts_t sts_o,
  input  wire rat_pkg::in_t  in_data_i,
  output      logic          out_valid_o,
  input  wire logic          out_stall_i,
  output      rat_pkg::out_t out_data_o
);
  import rat_pkg::*;

  // item and derived key
  in_t                 item_q;
  logic [31:0]         prod_q;
  logic [UnitBits-1:0] unit_q;
  logic                bad_q;
  logic                is_img, is_buf, bad_d;
  logic [FmtBits-1:0]  key_fmt;

  // key store for the parallel compare
  logic [TableEntries-1:0] valid_q;
  logic [CatBits-1:0]      cam_cat_q  [TableEntries];
  logic [FmtBits-1:0]      cam_fmt_q  [TableEntries];
  logic [UnitBits-1:0]     cam_unit_q [TableEntries];

  // lookup results
  logic [TableEntries-1:0] hit_vec;
  logic                    hit_d, free_d;
  logic [SlotBits-1:0]     hit_idx, free_idx, addr_d;
  logic                    hit_q, full_q, sel_valid_q;
  logic [SlotBits-1:0]     slot_q;

  // entry ram
  logic ram_we;
  rec_t ram_wdata, ram_rdata;

  // update results
  rec_t                  res_rec_q, res_rec_d;
  logic [2:0]            res_status_q, res_status_d;
  logic [SlotBits-1:0]   res_slot_q, res_slot_d;
  logic                  res_show_q, res_show_d;
  logic                  set_valid, clr_valid;
  logic                  tot_inc, tot_dec;

  logic [TotCntBits-1:0]   img_cnt_q, buf_cnt_q;
  logic [TotBytesBits-1:0] img_bytes_q, buf_bytes_q;

  // output register
  logic out_valid_q;
  out_t out_q;
  logic [BytesBits-1:0] res_bytes;

  assign is_img  = (item_q.opcode == OP_TRACK_IMG) || (item_q.opcode == OP_UNTRACK_IMG);
  assign is_buf  = (item_q.opcode == OP_TRACK_BUF) || (item_q.opcode == OP_UNTRACK_BUF);
  assign key_fmt = is_buf ? BufferFormat : item_q.format_code;

  // request checks
  always_comb begin
    bad_d = 1'b0;
    case (item_q.opcode)
      OP_TRACK_IMG, OP_UNTRACK_IMG:
        bad_d = (item_q.format_code >= NumFormats) || (item_q.width == '0) ||
                (item_q.height == '0);
      OP_TRACK_BUF, OP_UNTRACK_BUF: bad_d = (item_q.byte_count == '0);
      OP_CLEAR, OP_TOTALS:          bad_d = 1'b0;
      OP_READ:    bad_d = (32'(item_q.slot_select) >= TableEntries);
      default:    bad_d = 1'b1;
    endcase
  end

  // item capture and the two size multiplies
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      item_q <= in_data_i;
    end
    if (cmd_i.mul_wh) begin
      prod_q <= item_q.width * item_q.height;
    end
    if (cmd_i.mul_bpp) begin
      bad_q  <= bad_d;
      unit_q <= is_buf ? UnitBits'(item_q.byte_count)
                       : UnitBits'(prod_q) * UnitBits'(pixel_bytes(item_q.format_code));
    end
  end

  // parallel key compare over all entries
  always_comb begin
    for (int i = 0; i < TableEntries; i++) begin
      hit_vec[i] = valid_q[i] && (cam_cat_q[i] == item_q.category_id) &&
                   (cam_fmt_q[i] == key_fmt) && (cam_unit_q[i] == unit_q);
    end
  end

  // lowest match and lowest free slot
  always_comb begin
    hit_d    = 1'b0;
    free_d   = 1'b0;
    hit_idx  = '0;
    free_idx = '0;
    for (int i = TableEntries - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        hit_d   = 1'b1;
        hit_idx = SlotBits'(i);
      end
      if (!valid_q[i]) begin
        free_d   = 1'b1;
        free_idx = SlotBits'(i);
      end
    end
    if (item_q.opcode == OP_READ) begin
      addr_d = item_q.slot_select[SlotBits-1:0];
    end else if (hit_d) begin
      addr_d = hit_idx;
    end else begin
      addr_d = free_idx;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.lookup) begin
      hit_q       <= hit_d;
      full_q      <= !free_d;
      slot_q      <= addr_d;
      sel_valid_q <= valid_q[item_q.slot_select[SlotBits-1:0]];
    end
  end

  // ram writes only in the update step
  rat_ram #(
    .Width (RecBits),
    .Depth (TableEntries)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we && cmd_i.update),
    .addr_i  (slot_q),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // per operation table update
  always_comb begin
    ram_we       = 1'b0;
    ram_wdata    = ram_rdata;
    res_rec_d    = ram_rdata;
    res_status_d = ST_OK;
    res_slot_d   = '0;
    res_show_d   = 1'b0;
    set_valid    = 1'b0;
    clr_valid    = 1'b0;
    tot_inc      = 1'b0;
    tot_dec      = 1'b0;
    if (bad_q) begin
      res_status_d = ST_INVALID;
    end else begin
      case (item_q.opcode)
        OP_TRACK_IMG, OP_TRACK_BUF: begin
          if (hit_q) begin
            res_slot_d = slot_q;
            res_show_d = 1'b1;
            if (ram_rdata.count == CountMax) begin
              res_status_d = ST_SAT;
            end else begin
              ram_wdata.count = ram_rdata.count + 1'b1;
              if (is_img) begin
                ram_wdata.size = {item_q.height, item_q.width};
              end
              ram_we    = 1'b1;
              res_rec_d = ram_wdata;
              tot_inc   = 1'b1;
            end
          end else if (full_q) begin
            res_status_d = ST_FULL;
          end else begin
            ram_wdata.cat   = item_q.category_id;
            ram_wdata.fmt   = key_fmt;
            ram_wdata.unit  = unit_q;
            ram_wdata.count = CountBits'(1);
            ram_wdata.size  = is_img ? {item_q.height, item_q.width} : '0;
            ram_we          = 1'b1;
            set_valid       = 1'b1;
            res_rec_d       = ram_wdata;
            res_slot_d      = slot_q;
            res_show_d      = 1'b1;
            tot_inc         = 1'b1;
          end
        end
        OP_UNTRACK_IMG, OP_UNTRACK_BUF: begin
          if (hit_q) begin
            ram_wdata.count = ram_rdata.count - 1'b1;
            ram_we          = 1'b1;
            clr_valid       = (ram_wdata.count == '0);
            res_rec_d       = ram_wdata;
            res_slot_d      = slot_q;
            res_show_d      = 1'b1;
            tot_dec         = 1'b1;
          end else begin
            res_status_d = ST_NOT_FOUND;
          end
        end
        OP_READ: begin
          res_slot_d = slot_q;
          if (sel_valid_q) begin
            res_show_d = 1'b1;
          end else begin
            res_status_d = ST_EMPTY;
          end
        end
        default: res_status_d = ST_OK;
      endcase
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (cmd_i.update) begin
      if (!bad_q && item_q.opcode == OP_CLEAR) begin
        valid_q <= '0;
      end else if (set_valid) begin
        valid_q[slot_q] <= 1'b1;
      end else if (clr_valid) begin
        valid_q[slot_q] <= 1'b0;
      end
    end
  end

  // keys of a claimed entry, and the registered update results
  always_ff @(posedge clk_i) begin
    if (cmd_i.update && set_valid) begin
      cam_cat_q[slot_q]  <= item_q.category_id;
      cam_fmt_q[slot_q]  <= key_fmt;
      cam_unit_q[slot_q] <= unit_q;
    end
    if (cmd_i.update) begin
      res_rec_q    <= res_rec_d;
      res_status_q <= res_status_d;
      res_slot_q   <= res_slot_d;
      res_show_q   <= res_show_d;
    end
  end

  // running totals, moved by one instance per track or untrack, zeroed by clear
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_cnt_q   <= '0;
      img_bytes_q <= '0;
      buf_cnt_q   <= '0;
      buf_bytes_q <= '0;
    end else if (cmd_i.update) begin
      if (!bad_q && item_q.opcode == OP_CLEAR) begin
        img_cnt_q   <= '0;
        img_bytes_q <= '0;
        buf_cnt_q   <= '0;
        buf_bytes_q <= '0;
      end else if (tot_inc && is_buf) begin
        buf_cnt_q   <= buf_cnt_q + 1'b1;
        buf_bytes_q <= buf_bytes_q + TotBytesBits'(unit_q);
      end else if (tot_inc) begin
        img_cnt_q   <= img_cnt_q + 1'b1;
        img_bytes_q <= img_bytes_q + TotBytesBits'(unit_q);
      end else if (tot_dec && is_buf) begin
        buf_cnt_q   <= buf_cnt_q - 1'b1;
        buf_bytes_q <= buf_bytes_q - TotBytesBits'(unit_q);
      end else if (tot_dec) begin
        img_cnt_q   <= img_cnt_q - 1'b1;
        img_bytes_q <= img_bytes_q - TotBytesBits'(unit_q);
      end
    end
  end

  // entry bytes of the shown entry
  assign res_bytes = BytesBits'(res_rec_q.count * res_rec_q.unit);

  // result register and its transfer
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q.status         <= res_status_q;
      out_q.slot_index     <= 6'(res_slot_q);
      out_q.entry_category <= res_show_q ? res_rec_q.cat : '0;
      out_q.entry_format   <= res_show_q ? res_rec_q.fmt : '0;
      out_q.entry_count    <= res_show_q ? res_rec_q.count : '0;
      out_q.entry_bytes    <= res_show_q ? res_bytes : '0;
      out_q.entry_width    <= res_show_q ? res_rec_q.size[15:0] : '0;
      out_q.entry_height   <= res_show_q ? res_rec_q.size[31:16] : '0;
      out_q.image_count    <= img_cnt_q;
      out_q.image_bytes    <= img_bytes_q;
      out_q.buffer_count   <= buf_cnt_q;
      out_q.buffer_bytes   <= buf_bytes_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ----- sv/resource_accounting_table.sv -----
// resource_accounting_table: top level, sequencer plus datapath
// depends on rat_pkg, rat_ctrl, rat_dpath and rat_ram
`default_nettype none

// Keeps a 64-entry table of live resources keyed by category, format and bytes
// per instance, with running image and buffer totals. One item is worked on at
// a time, in steps from transfer in to result: width times height, times bytes
// per pixel, a parallel key compare with free-slot search, an entry ram read,
// then the update and the entry byte multiply into the result register. A new
// item is taken while the previous result still waits. The entry ram needs no
// clearing after reset; the table is usable at once.
module resource_accounting_table (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output      logic          in_stall_o,
  input  wire rat_pkg::in_t  in_data_i,
  output      logic          out_valid_o,
  input  wire logic          out_stall_i,
  output      rat_pkg::out_t out_data_o
);
  import rat_pkg::*;

  cmd_t cmd;
  sts_t sts;

  rat_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rat_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// ----- dv/rat_checker.sv -----
// rat_checker: watches both channels of the resource accounting table, predicts
// each result from its own copy of the table and compares; depends on rat_pkg
`default_nettype none

module rat_checker (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire logic          in_stall_i,
  input  wire rat_pkg::in_t  in_data_i,
  input  wire logic          out_valid_i,
  input  wire logic          out_stall_i,
  input  wire rat_pkg::out_t out_data_i,
  output int                 errors_o,
  output int                 pending_o
);
  import rat_pkg::*;

  localparam int Slots = 64;

  // shadow copy of the table
  bit                    live_q   [Slots];
  logic [CatBits-1:0]    cat_q    [Slots];
  logic [FmtBits-1:0]    fmt_q    [Slots];
  logic [UnitBits-1:0]   unit_q   [Slots];
  logic [CountBits-1:0]  cnt_q    [Slots];
  logic [SizeBits-1:0]   size_q   [Slots];
  logic [TotBytesBits-1:0] sums_q [4];

  out_t expected_results[$];
  int   mismatches = 0;

  function automatic logic [3:0] fmt_pixel_bytes(logic [FmtBits-1:0] f);
    case (f)
      4'd1:         return 4'd8;
      4'd2, 4'd4:   return 4'd2;
      4'd8:         return 4'd12;
      4'd9:         return 4'd1;
      4'd10:        return 4'd3;
      default:      return 4'd4;
    endcase
  endfunction

  function automatic logic [BytesBits-1:0] slot_bytes(int s);
    logic [BytesBits-1:0] p;
    p = BytesBits'(cnt_q[s]) * BytesBits'(unit_q[s]);
    return p;
  endfunction

  function automatic void refresh_sums();
    logic [TotBytesBits-1:0] t [4];
    for (int k = 0; k < 4; k++) t[k] = '0;
    for (int i = 0; i < Slots; i++) begin
      if (live_q[i]) begin
        if (fmt_q[i] == BufferFormat) begin
          t[2] += cnt_q[i];
          t[3] += slot_bytes(i);
        end else begin
          t[0] += cnt_q[i];
          t[1] += slot_bytes(i);
        end
      end
    end
    for (int k = 0; k < 4; k++) sums_q[k] = t[k];
  endfunction

  function automatic out_t make_result(logic [2:0] st, int s, bit show);
    out_t r;
    r = '0;
    r.status = st;
    if (s >= 0) begin
      r.slot_index = s[5:0];
      if (show) begin
        r.entry_category = cat_q[s];
        r.entry_format   = fmt_q[s];
        r.entry_count    = cnt_q[s];
        r.entry_bytes    = slot_bytes(s);
        r.entry_width    = size_q[s][15:0];
        r.entry_height   = size_q[s][31:16];
      end
    end
    r.image_count  = sums_q[0][TotCntBits-1:0];
    r.image_bytes  = sums_q[1];
    r.buffer_count = sums_q[2][TotCntBits-1:0];
    r.buffer_bytes = sums_q[3];
    return r;
  endfunction

  function automatic int find_slot(logic [CatBits-1:0] c, logic [FmtBits-1:0] f,
                                   logic [UnitBits-1:0] u);
    for (int i = 0; i < Slots; i++)
      if (live_q[i] && unit_q[i] == u && fmt_q[i] == f && cat_q[i] == c) return i;
    return -1;
  endfunction

  function automatic out_t track(logic [CatBits-1:0] c, logic [FmtBits-1:0] f,
                                 logic [UnitBits-1:0] u, bit img, logic [31:0] sz);
    int s;
    s = find_slot(c, f, u);
    if (s < 0) begin
      for (int i = 0; i < Slots && s < 0; i++) if (!live_q[i]) s = i;
      if (s < 0) return make_result(ST_FULL, -1, 0);
      live_q[s] = 1; cat_q[s] = c; fmt_q[s] = f; unit_q[s] = u;
      cnt_q[s] = '0; size_q[s] = '0;
    end else if (cnt_q[s] == CountMax) begin
      return make_result(ST_SAT, s, 1);
    end
    cnt_q[s] = cnt_q[s] + 1'b1;
    if (img) size_q[s] = sz;
    refresh_sums();
    return make_result(ST_OK, s, 1);
  endfunction

  function automatic out_t untrack(logic [CatBits-1:0] c, logic [FmtBits-1:0] f,
                                   logic [UnitBits-1:0] u);
    int s;
    s = find_slot(c, f, u);
    if (s < 0) return make_result(ST_NOT_FOUND, -1, 0);
    if (cnt_q[s] != 0) cnt_q[s] = cnt_q[s] - 1'b1;
    if (cnt_q[s] == 0) live_q[s] = 0;
    refresh_sums();
    return make_result(ST_OK, s, 1);
  endfunction

  // expected result of one accepted transfer
  function automatic out_t predict_result(in_t x);
    logic [UnitBits-1:0] u;
    case (x.opcode)
      OP_TRACK_IMG, OP_UNTRACK_IMG: begin
        if (x.format_code >= NumFormats || x.width == 0 || x.height == 0)
          return make_result(ST_INVALID, -1, 0);
        u = UnitBits'(x.width) * UnitBits'(x.height) *
            UnitBits'(fmt_pixel_bytes(x.format_code));
        if (x.opcode == OP_TRACK_IMG)
          return track(x.category_id, x.format_code, u, 1, {x.height, x.width});
        return untrack(x.category_id, x.format_code, u);
      end
      OP_TRACK_BUF, OP_UNTRACK_BUF: begin
        if (x.byte_count == 0) return make_result(ST_INVALID, -1, 0);
        u = UnitBits'(x.byte_count);
        if (x.opcode == OP_TRACK_BUF)
          return track(x.category_id, BufferFormat, u, 0, '0);
        return untrack(x.category_id, BufferFormat, u);
      end
      OP_CLEAR: begin
        for (int i = 0; i < Slots; i++) begin
          live_q[i] = 0;
          cnt_q[i]  = '0;
        end
        refresh_sums();
        return make_result(ST_OK, -1, 0);
      end
      OP_TOTALS: return make_result(ST_OK, -1, 0);
      OP_READ: begin
        if (!live_q[x.slot_select]) return make_result(ST_EMPTY, x.slot_select, 0);
        return make_result(ST_OK, x.slot_select, 1);
      end
      default: return make_result(ST_INVALID, -1, 0);
    endcase
  endfunction

  function automatic bit field_ok(string name, logic [63:0] e, logic [63:0] a, bit loud);
    if (e === a) return 1;
    if (loud) $display("  %s expected %0h actual %0h", name, e, a);
    return 0;
  endfunction

  function automatic void compare_result(out_t e, out_t a);
    bit ok, loud;
    loud = (mismatches < 10);
    if (a === e) return;
    if (loud) $display("mismatch at %0t", $realtime);
    ok = field_ok("status", e.status, a.status, loud);
    ok = field_ok("slot_index", e.slot_index, a.slot_index, loud) && ok;
    ok = field_ok("entry_category", e.entry_category, a.entry_category, loud) && ok;
    ok = field_ok("entry_format", e.entry_format, a.entry_format, loud) && ok;
    ok = field_ok("entry_count", e.entry_count, a.entry_count, loud) && ok;
    ok = field_ok("entry_bytes", e.entry_bytes, a.entry_bytes, loud) && ok;
    ok = field_ok("entry_width", e.entry_width, a.entry_width, loud) && ok;
    ok = field_ok("entry_height", e.entry_height, a.entry_height, loud) && ok;
    ok = field_ok("image_count", e.image_count, a.image_count, loud) && ok;
    ok = field_ok("image_bytes", e.image_bytes, a.image_bytes, loud) && ok;
    ok = field_ok("buffer_count", e.buffer_count, a.buffer_count, loud) && ok;
    ok = field_ok("buffer_bytes", e.buffer_bytes, a.buffer_bytes, loud) && ok;
    mismatches++;
  endfunction

  // prediction on input transfers, comparison on output transfers
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Slots; i++) begin
        live_q[i] = 0; cnt_q[i] = '0; cat_q[i] = '0;
        fmt_q[i] = '0; unit_q[i] = '0; size_q[i] = '0;
      end
      for (int k = 0; k < 4; k++) sums_q[k] = '0;
    end else begin
      if (out_valid_i === 1'b1 && out_stall_i === 1'b0) begin
        if (expected_results.size() == 0) begin
          if (mismatches < 10) $display("result with nothing expected at %0t", $realtime);
          mismatches++;
        end else begin
          compare_result(expected_results.pop_front(), out_data_i);
        end
      end
      if (in_valid_i === 1'b1 && in_stall_i === 1'b0)
        expected_results.push_back(predict_result(in_data_i));
    end
    pending_o = expected_results.size();
    errors_o  = mismatches;
  end

endmodule

`default_nettype wire

// ----- dv/resource_accounting_table_tb.sv -----
// resource_accounting_table_tb: stimulus and verdict for the accounting table
// depends on rat_pkg, resource_accounting_table and rat_checker
`default_nettype none

module resource_accounting_table_tb;
  import rat_pkg::*;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  in_t  in_data_i;
  logic out_valid_o;
  logic out_stall_i;
  out_t out_data_o;
  int   errors;
  int   pending;

  bit quiet;       // no idling on either side
  bit hold_go;     // ask the receiver for a long hold-off
  bit hold_done;

  resource_accounting_table dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o
  );

  rat_checker u_checker (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_i(in_stall_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_stall_i, .out_data_i(out_data_o),
    .errors_o(errors), .pending_o(pending)
  );

  // clock
  initial clk_i = 1'b0;
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // overall limit
  initial begin
    #10_000_000;
    $display("status: fail");
    $finish;
  end

  // receiver side stall bursts and one long hold-off
  initial begin
    out_stall_i = 1'b0;
    hold_done   = 0;
    forever begin
      @(posedge clk_i);
      if (hold_go && !hold_done) begin
        out_stall_i <= 1'b1;
        repeat (400) @(posedge clk_i);
        out_stall_i <= 1'b0;
        hold_done = 1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // one transfer, held until accepted
  task automatic send(in_t x);
    bit taken;
    in_valid_i <= 1'b1;
    in_data_i  <= x;
    do begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end while (!taken);
  endtask

  task automatic sender_gap();
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
  endtask

  function automatic in_t item(logic [2:0] op, logic [7:0] cat, logic [3:0] fmt,
                               logic [15:0] w, logic [15:0] h, logic [31:0] b,
                               logic [5:0] sel);
    in_t x;
    x.opcode = op; x.category_id = cat; x.format_code = fmt;
    x.width = w; x.height = h; x.byte_count = b; x.slot_select = sel;
    return x;
  endfunction

  // random item, mostly well formed with keys from a small pool
  function automatic in_t random_item();
    in_t x;
    int  pick;
    x = item(3'($urandom), 8'($urandom), 4'($urandom), 16'($urandom), 16'($urandom),
             $urandom, 6'($urandom));
    pick = $urandom_range(0, 99);
    if (pick >= 97) return x;  // pure noise
    x.category_id = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
    x.format_code = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(11, 15))
                                                : 4'($urandom_range(0, 10));
    case ($urandom_range(0, 3))
      0:       begin x.width = 16'hffff; x.height = 16'($urandom_range(1, 2)); end
      1:       begin x.width = 16'($urandom_range(0, 3)); x.height = 16'($urandom_range(0, 3)); end
      default: begin x.width = 16'($urandom_range(1, 2)); x.height = 16'($urandom_range(1, 2)); end
    endcase
    if ($urandom_range(0, 3) != 0) x.byte_count = $urandom_range(0, 3);
    if (pick < 28)      x.opcode = OP_TRACK_IMG;
    else if (pick < 46) x.opcode = OP_UNTRACK_IMG;
    else if (pick < 62) x.opcode = OP_TRACK_BUF;
    else if (pick < 78) x.opcode = OP_UNTRACK_BUF;
    else if (pick < 83) x.opcode = OP_TOTALS;
    else if (pick < 93) x.opcode = OP_READ;
    else if (pick < 94) x.opcode = OP_CLEAR;
    else                x.opcode = 3'b111;
    return x;
  endfunction

  // pause the sender until every expected result has come
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    @(posedge clk_i);
  endtask

  initial begin
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_data_i  = '0;
    quiet      = 0;
    hold_go    = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: every operation, extremes and the special cases
    send(item(OP_TOTALS, 0, 0, 0, 0, 0, 0));
    send(item(OP_READ, 0, 0, 0, 0, 0, 6'd63));
    send(item(OP_UNTRACK_IMG, 8'd1, 4'd0, 16'd2, 16'd2, 0, 0));
    send(item(OP_TRACK_IMG, 8'hff, 4'd8, 16'hffff, 16'hffff, 0, 0));
    send(item(OP_TRACK_IMG, 8'hff, 4'd8, 16'hffff, 16'hffff, 0, 0));
    send(item(OP_TRACK_IMG, 8'd0, 4'd9, 16'd1, 16'd1, 0, 0));
    send(item(OP_TRACK_IMG, 8'd0, 4'd11, 16'd1, 16'd1, 0, 0));
    send(item(OP_TRACK_IMG, 8'd0, 4'd15, 16'd1, 16'd1, 0, 0));
    send(item(OP_TRACK_IMG, 8'd0, 4'd1, 16'd0, 16'd5, 0, 0));
    send(item(OP_UNTRACK_IMG, 8'd0, 4'd1, 16'd5, 16'd0, 0, 0));
    send(item(OP_TRACK_BUF, 8'd3, 4'd0, 0, 0, 32'hffffffff, 0));
    send(item(OP_TRACK_BUF, 8'd3, 4'd7, 16'd9, 16'd9, 32'hffffffff, 0));
    send(item(OP_TRACK_BUF, 8'd3, 0, 0, 0, 32'd0, 0));
    send(item(OP_UNTRACK_BUF, 8'd3, 0, 0, 0, 32'd0, 0));
    send(item(OP_UNTRACK_BUF, 8'd4, 0, 0, 0, 32'd1, 0));
    send(item(OP_READ, 0, 0, 0, 0, 0, 6'd0));
    send(item(OP_READ, 0, 0, 0, 0, 0, 6'd2));
    send(item(OP_UNTRACK_BUF, 8'd3, 0, 0, 0, 32'hffffffff, 0));
    send(item(OP_UNTRACK_BUF, 8'd3, 0, 0, 0, 32'hffffffff, 0));
    send(item(OP_UNTRACK_IMG, 8'd0, 4'd9, 16'd1, 16'd1, 0, 0));
    send(item(OP_READ, 0, 0, 0, 0, 0, 6'd1));
    send(item(3'b111, 8'hff, 4'hf, 16'hffff, 16'hffff, 32'hffffffff, 6'h3f));
    send(item(OP_TRACK_IMG, 8'd7, 4'd10, 16'd3, 16'd640, 0, 0));
    send(item(OP_TOTALS, 0, 0, 0, 0, 0, 0));
    send(item(OP_CLEAR, 0, 0, 0, 0, 0, 0));

    // fill the table, then a further buffer track and an image track are dropped
    for (int i = 1; i <= 65; i++) send(item(OP_TRACK_BUF, 8'd9, 0, 0, 0, 32'(i), 0));
    send(item(OP_TRACK_IMG, 8'd9, 4'd0, 16'd1, 16'd1, 0, 0));
    send(item(OP_READ, 0, 0, 0, 0, 0, 6'd63));
    send(item(OP_CLEAR, 0, 0, 0, 0, 0, 0));

    // long receiver hold-off while items keep coming
    hold_go = 1;
    for (int i = 0; i < 40; i++) send(random_item());
    wait_drained();

    // random traffic, the last part without idling
    for (int i = 0; i < 1160; i++) begin
      if (i == 1000) quiet = 1;
      if (i == 500) wait_drained();
      sender_gap();
      send(random_item());
    end
    in_valid_i <= 1'b0;

    // drain and settle
    fork
      do @(negedge clk_i); while (pending != 0);
      begin
        repeat (20000) @(posedge clk_i);
        $display("status: fail");
        $finish;
      end
    join_any
    disable fork;
    repeat (20) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- filelist.f -----
sv/rat_pkg.sv
sv/rat_ram.sv
sv/rat_ctrl.sv
sv/rat_dpath.sv
sv/resource_accounting_table.sv
dv/rat_checker.sv
dv/resource_accounting_table_tb.sv
